@@ hw/rtl/pcc_pkg.sv @@
// Package: shared widths, register indexes, limits and the sequencer state type.
package pcc_pkg;

    localparam int FEAT_W   = 16;
    localparam int LABEL_W  = 10;
    localparam int COST_W   = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_DIMS   = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_OFFSET = 8'd1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ZFILL,
        S_OFF,
        S_OFFW,
        S_LBL,
        S_LCMP,
        S_DOT,
        S_FLUSH,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/pcc_if.sv @@
// Interfaces: point input channel, result channel and register write channel.
interface pcc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcc_pkg::FEAT_W-1:0]  feature_value;
    logic        [pcc_pkg::LABEL_W-1:0] point_label;
    logic                                last_item;
    modport source (output valid, feature_value, point_label, last_item, input ready);
    modport sink   (input valid, feature_value, point_label, last_item, output ready);
endinterface

interface pcc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pcc_pkg::COST_W-1:0] cut_cost;
    logic                               saturated;
    modport source (output valid, cut_cost, saturated, input ready);
    modport sink   (input valid, cut_cost, saturated, output ready);
endinterface

interface pcc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [pcc_pkg::CFG_IDX_W-1:0]        index;
    logic [pcc_pkg::CFG_DATA_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/pairwise_cut_cost.sv @@
// Top level: labeled point loader and cut-pair dot product accumulator.
// Load: one component per cycle into the feature memory; input ready in the load state.
// Compute: after the last transaction, zero-fill the open point, read the offset component,
//   then per pair look up both labels and, for a cut pair, issue the dot-product terms and
//   a closing step (offset term when enabled); drain the pipeline, then emit.
// The result waits in an output register; loading of the next set proceeds meanwhile.
// Reset (synchronous, active low) clears state, cfg, load counts, valids and acc; not memories.
module pairwise_cut_cost #(
    parameter int MAX_POINTS = pcc_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = pcc_pkg::DEF_MAX_DIMS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcc_in_if.sink    i_in,
    pcc_out_if.source o_res,
    pcc_cfg_if.sink   i_cfg
);
    import pcc_pkg::*;

    localparam int PW   = $clog2(MAX_POINTS);          // point address
    localparam int PCW  = $clog2(MAX_POINTS + 1);      // point count
    localparam int CW   = $clog2(MAX_DIMS + 1);        // component count
    localparam int FDEP = MAX_POINTS * MAX_DIMS;
    localparam int FAW  = $clog2(FDEP);

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_num_dims;
    logic                  r_sub_off;

    // Memories
    logic signed [FEAT_W-1:0] r_feat_mem [FDEP];
    logic [LABEL_W-1:0]       r_lbl_mem  [MAX_POINTS];
    logic signed [FEAT_W-1:0] r_rd_a, r_rd_b;
    logic [LABEL_W-1:0]       r_lbl_a, r_lbl_b;

    // Control and counters
    t_state          r_state, n_state;
    logic [PCW-1:0]  r_pcnt;
    logic [CW-1:0]   r_comp;
    logic [PCW-1:0]  r_n;
    logic [PW-1:0]   r_zf_pt;
    logic [CW-1:0]   r_zf_k;
    logic [PCW-1:0]  r_i, r_j;
    logic [CW-1:0]   r_l;
    logic signed [2*FEAT_W-1:0] r_off_sq;

    // Accumulate pipeline: read stage, term stage, add
    logic r_v1, r_k1;          // valid, offset token
    logic r_v2;
    logic signed [COST_W-1:0] r_term;
    logic signed [COST_W-1:0] r_acc;
    logic                     r_ovf;

    // Output register
    logic                     r_out_valid;
    logic signed [COST_W-1:0] r_out_cost;
    logic                     r_out_sat;

    // Combinational control
    logic [CW-1:0]  d_eff, de;
    logic [CW-1:0]  c_cl;
    logic           stored;
    logic           in_acc;
    logic           fe_we;
    logic [FAW-1:0] fe_waddr;
    logic signed [FEAT_W-1:0] fe_wdata;
    logic           fe_re;
    logic [FAW-1:0] fe_ra, fe_rb;
    logic           issue, issue_off;
    logic [PCW-1:0] adv_i, adv_j;
    logic           adv_end;
    logic           cut;

    assign i_cfg.ready = 1'b1;

    // Effective dimensions: zero counts as one, clamp at MAX_DIMS
    always_comb begin
        if (r_num_dims == '0) begin
            d_eff = CW'(1);
        end else if (32'(r_num_dims) > MAX_DIMS) begin
            d_eff = CW'(MAX_DIMS);
        end else begin
            d_eff = CW'(r_num_dims);
        end
        de     = r_sub_off ? d_eff - CW'(1) : d_eff;
        c_cl   = (32'(r_comp) < MAX_DIMS) ? r_comp : CW'(MAX_DIMS - 1);
        stored = 32'(r_pcnt) < MAX_POINTS;
    end

    // Next pair in row-major upper-triangle order
    always_comb begin
        if (r_j + PCW'(1) < r_n) begin
            adv_i   = r_i;
            adv_j   = r_j + PCW'(1);
            adv_end = 1'b0;
        end else begin
            adv_i   = r_i + PCW'(1);
            adv_j   = r_i + PCW'(2);
            adv_end = !(r_i + PCW'(2) < r_n);
        end
    end

    assign cut = (r_lbl_a != r_lbl_b);

    // State machine: next state and memory control
    always_comb begin
        n_state   = r_state;
        i_in.ready = 1'b0;
        in_acc    = 1'b0;
        fe_we     = 1'b0;
        fe_waddr  = FAW'(32'(r_pcnt) * MAX_DIMS + 32'(c_cl));
        fe_wdata  = i_in.feature_value;
        fe_re     = 1'b0;
        fe_ra     = FAW'(32'(r_i) * MAX_DIMS + 32'(r_l));
        fe_rb     = FAW'(32'(r_j) * MAX_DIMS + 32'(r_l));
        issue     = 1'b0;
        issue_off = 1'b0;
        case (r_state)
            S_LOAD: begin
                i_in.ready = 1'b1;
                in_acc     = i_in.valid;
                fe_we      = i_in.valid && stored;
                if (i_in.valid && i_in.last_item) begin
                    if (stored && (c_cl + CW'(1) < d_eff)) begin
                        n_state = S_ZFILL;
                    end else begin
                        n_state = S_OFF;
                    end
                end
            end
            S_ZFILL: begin
                fe_we    = 1'b1;
                fe_waddr = FAW'(32'(r_zf_pt) * MAX_DIMS + 32'(r_zf_k));
                fe_wdata = '0;
                if (r_zf_k + CW'(1) >= d_eff) begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                fe_re   = 1'b1;
                fe_ra   = FAW'(32'(d_eff) - 1);
                n_state = S_OFFW;
            end
            S_OFFW: begin
                n_state = (r_n < PCW'(2)) ? S_FLUSH : S_LBL;
            end
            S_LBL: begin
                n_state = S_LCMP;
            end
            S_LCMP: begin
                if (cut) begin
                    n_state = S_DOT;
                end else begin
                    n_state = adv_end ? S_FLUSH : S_LBL;
                end
            end
            S_DOT: begin
                if (r_l < de) begin
                    fe_re = 1'b1;
                    issue = 1'b1;
                end else begin
                    issue_off = r_sub_off;
                    n_state   = adv_end ? S_FLUSH : S_LBL;
                end
            end
            S_FLUSH: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Feature memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (fe_we) begin
            r_feat_mem[fe_waddr] <= fe_wdata;
        end
        if (fe_re) begin
            r_rd_a <= r_feat_mem[fe_ra];
            r_rd_b <= r_feat_mem[fe_rb];
        end
    end

    // Label memory: written on a point's first component, read per pair
    always_ff @(posedge i_clk) begin
        if (in_acc && stored && c_cl == '0) begin
            r_lbl_mem[PW'(r_pcnt)] <= i_in.point_label;
        end
        if (r_state == S_LBL) begin
            r_lbl_a <= r_lbl_mem[PW'(r_i)];
            r_lbl_b <= r_lbl_mem[PW'(r_j)];
        end
    end

    // Saturating 64-bit add; flags overflow
    function automatic logic [COST_W:0] sat_add(input logic signed [COST_W-1:0] a,
                                                input logic signed [COST_W-1:0] b);
        logic signed [COST_W-1:0] s;
        logic                     o;
        s = a + b;
        o = (a[COST_W-1] == b[COST_W-1]) && (s[COST_W-1] != a[COST_W-1]);
        if (o) begin
            s = b[COST_W-1] ? {1'b1, {(COST_W-1){1'b0}}} : {1'b0, {(COST_W-1){1'b1}}};
        end
        return {o, s};
    endfunction

    logic [COST_W:0] acc_sum;
    assign acc_sum = sat_add(r_acc, r_term);

    // Counters, sequencer registers and accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= CFG_DATA_W'(1);
            r_sub_off  <= 1'b0;
            r_pcnt     <= '0;
            r_comp     <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_NUM_DIMS:   r_num_dims <= i_cfg.data;
                    REG_SUB_OFFSET: r_sub_off  <= i_cfg.data[0];
                    default: ;
                endcase
            end

            // Load: advance component and point counters
            if (in_acc) begin
                if (i_in.last_item) begin
                    r_n     <= stored ? r_pcnt + PCW'(1) : r_pcnt;
                    r_zf_pt <= PW'(r_pcnt);
                    r_zf_k  <= c_cl + CW'(1);
                    r_pcnt  <= '0;
                    r_comp  <= '0;
                end else if (c_cl + CW'(1) >= d_eff) begin
                    r_comp <= '0;
                    if (stored) begin
                        r_pcnt <= r_pcnt + PCW'(1);
                    end
                end else begin
                    r_comp <= c_cl + CW'(1);
                end
            end

            if (r_state == S_ZFILL) begin
                r_zf_k <= r_zf_k + CW'(1);
            end

            // Offset: square point 0's last component; clear accumulator
            if (r_state == S_OFF) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
            end
            if (r_state == S_OFFW) begin
                r_off_sq <= r_rd_a * r_rd_a;
                r_i      <= '0;
                r_j      <= PCW'(1);
            end

            // Pair walk
            if (r_state == S_LCMP) begin
                r_l <= '0;
                if (!cut) begin
                    r_i <= adv_i;
                    r_j <= adv_j;
                end
            end
            if (r_state == S_DOT) begin
                if (r_l < de) begin
                    r_l <= r_l + CW'(1);
                end else begin
                    r_i <= adv_i;
                    r_j <= adv_j;
                end
            end

            // Pipeline: read, form term, saturating add
            r_v1 <= issue || issue_off;
            r_k1 <= issue_off;
            r_v2 <= r_v1;
            if (r_v1) begin
                r_term <= r_k1 ? -COST_W'(r_off_sq) : COST_W'(r_rd_a * r_rd_b);
            end
            if (r_v2) begin
                r_acc <= acc_sum[COST_W-1:0];
                if (acc_sum[COST_W]) begin
                    r_ovf <= 1'b1;
                end
            end

            // Output register: load on finish, else drop on take
            if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
                r_out_cost  <= r_acc;
                r_out_sat   <= r_ovf;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.cut_cost  = r_out_cost;
    assign o_res.saturated = r_out_sat;

endmodule

@@ hw/rtl/pcc_checker.sv @@
// Checker: port-level properties of the cut cost block, bound to the top level.
module pcc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              in_last,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [pcc_pkg::COST_W-1:0] out_cost,
    input logic                              out_sat
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_cost) && $stable(out_sat))
        else $error("result changed while stalled");

    // Stop input after the closing transaction
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input taken during computation");

    // A new result appears only at the end of a computation
    a_rise_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared during loading");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind pairwise_cut_cost pcc_checker u_pcc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_last   (i_in.last_item),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_cost  (o_res.cut_cost),
    .out_sat   (o_res.saturated)
);
